// File: hdl/c8ie_pkg.sv
package c8ie_pkg;

  // item kinds
  typedef enum logic [1:0] {
    OP_EXEC  = 2'd0,
    OP_WRITE = 2'd1,
    OP_READ  = 2'd2,
    OP_ROW   = 2'd3
  } item_op_t;

  // sequencer states
  typedef enum logic [4:0] {
    ST_IDLE,
    ST_RX,
    ST_RY,
    ST_R0,
    ST_EXEC,
    ST_MOD,
    ST_DRD,
    ST_DWR,
    ST_BCD,
    ST_STR,
    ST_STW,
    ST_LDR,
    ST_LDW,
    ST_HWR,
    ST_HRD,
    ST_HRC,
    ST_ROW,
    ST_ROWC,
    ST_WF,
    ST_FX,
    ST_FY,
    ST_FD
  } state_t;

  // where the modulo unit result goes
  typedef enum logic [1:0] {
    TGT_I,
    TGT_X,
    TGT_Y,
    TGT_HOST
  } mod_tgt_t;

  localparam logic [15:0] OPC_CLS = 16'h00e0;
  localparam logic [15:0] OPC_RET = 16'h00ee;

  localparam logic [3:0] GRP_JP   = 4'h1;
  localparam logic [3:0] GRP_CALL = 4'h2;
  localparam logic [3:0] GRP_SE   = 4'h3;
  localparam logic [3:0] GRP_SNE  = 4'h4;
  localparam logic [3:0] GRP_SER  = 4'h5;
  localparam logic [3:0] GRP_LD   = 4'h6;
  localparam logic [3:0] GRP_ADD  = 4'h7;
  localparam logic [3:0] GRP_ALU  = 4'h8;
  localparam logic [3:0] GRP_SNER = 4'h9;
  localparam logic [3:0] GRP_LDI  = 4'ha;
  localparam logic [3:0] GRP_JPV  = 4'hb;
  localparam logic [3:0] GRP_RND  = 4'hc;
  localparam logic [3:0] GRP_DRW  = 4'hd;
  localparam logic [3:0] GRP_KEY  = 4'he;
  localparam logic [3:0] GRP_MISC = 4'hf;

  localparam logic [3:0] ALU_MOV  = 4'h0;
  localparam logic [3:0] ALU_OR   = 4'h1;
  localparam logic [3:0] ALU_AND  = 4'h2;
  localparam logic [3:0] ALU_XOR  = 4'h3;
  localparam logic [3:0] ALU_ADD  = 4'h4;
  localparam logic [3:0] ALU_SUB  = 4'h5;
  localparam logic [3:0] ALU_SHR  = 4'h6;
  localparam logic [3:0] ALU_SUBN = 4'h7;
  localparam logic [3:0] ALU_SHL  = 4'he;

  localparam logic [7:0] KEY_DOWN = 8'h9e;
  localparam logic [7:0] KEY_UP   = 8'ha1;

  localparam logic [7:0] MISC_GDT = 8'h07;
  localparam logic [7:0] MISC_SDT = 8'h15;
  localparam logic [7:0] MISC_SST = 8'h18;
  localparam logic [7:0] MISC_ADI = 8'h1e;
  localparam logic [7:0] MISC_FNT = 8'h29;
  localparam logic [7:0] MISC_BCD = 8'h33;
  localparam logic [7:0] MISC_STR = 8'h55;
  localparam logic [7:0] MISC_LDR = 8'h65;

  localparam logic [3:0] FLAG_REG = 4'hf;
  localparam logic [2:0] MOD_STEPS = 3'd7;

  // decimal digit of an 8-bit value: sel 0 hundreds, 1 tens, 2 ones
  function automatic logic [7:0] bcd_digit(input logic [7:0] v, input logic [1:0] sel);
    logic [1:0]  h;
    logic [7:0]  r;
    logic [15:0] p;
    logic [3:0]  t;
    logic [7:0]  u;
    h = (v >= 8'd200) ? 2'd2 : ((v >= 8'd100) ? 2'd1 : 2'd0);
    r = v - ({6'b0, h} * 8'd100);
    p = 16'(r) * 16'd205;
    t = p[14:11];
    u = r - ({4'b0, t} * 8'd10);
    case (sel)
      2'd0:    bcd_digit = {6'b0, h};
      2'd1:    bcd_digit = {4'b0, t};
      default: bcd_digit = u;
    endcase
  endfunction

endpackage

// File: hdl/chip8_instruction_execute_core.sv
// plain opcodes read Vx, Vy and V0, execute, then read back VF and Vx (after a VF write
// for flag opcodes); Fx33, Fx55/Fx65, Dxyn and host byte accesses first reduce an
// address modulo the memory size, Dxyn also x and y modulo the screen size
// (every modulo by a memory or screen size runs 8 steps on one compare/subtract unit)
// one item at a time: busy stays high until the done strobe, which lasts one cycle
// synchronous reset: registers, timers, stack pointer and screen cleared, pc at 0x200
module chip8_instruction_execute_core
  import c8ie_pkg::*;
#(
  parameter int MEM_BYTES     = 4096,
  parameter int STACK_DEPTH   = 16,
  parameter int SCREEN_WIDTH  = 64,
  parameter int SCREEN_HEIGHT = 32,
  parameter int FONT_BYTES    = 5
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  output logic        done,
  input  logic [1:0]  op,
  input  logic [15:0] opcode,
  input  logic [15:0] keys_down,
  input  logic [7:0]  random_byte,
  input  logic [11:0] mem_addr,
  input  logic [7:0]  mem_data,
  output logic [11:0] prog_counter,
  output logic [15:0] index_value,
  output logic [7:0]  flag_value,
  output logic [7:0]  vx_value,
  output logic [7:0]  delay_count,
  output logic [7:0]  sound_count,
  output logic        screen_changed,
  output logic [7:0]  read_byte,
  output logic [63:0] screen_row
);

  localparam int MA_W  = $clog2(MEM_BYTES);
  localparam int SP_W  = $clog2(STACK_DEPTH);
  localparam int ROW_W = $clog2(SCREEN_HEIGHT);
  localparam int COL_W = $clog2(SCREEN_WIDTH);
  localparam int SW    = SCREEN_WIDTH;

  state_t   state, state_next;
  mod_tgt_t mod_tgt;

  // latched item
  logic [1:0]  op_q;
  logic [15:0] opc_q;
  logic [15:0] keys_q;
  logic [7:0]  rnd_q;
  logic [11:0] addr_q;
  logic [7:0]  data_q;

  // architectural state
  logic [11:0]      pc;
  logic [15:0]      index_reg;
  logic [SP_W-1:0]  sp;
  logic [7:0]       delay_reg;
  logic [7:0]       sound_reg;
  logic [15:0]      reg_valid;
  logic [SCREEN_HEIGHT-1:0] fb_valid;

  // working registers
  logic [7:0]       vx_q, vy_q, flag_q;
  logic [3:0]       cnt;
  logic [MA_W-1:0]  mptr;
  logic [ROW_W-1:0] rowptr;
  logic [COL_W-1:0] colbase;
  logic             hit;
  logic [15:0]      mod_acc;
  logic [16:0]      mod_div;
  logic [2:0]       mod_k;

  // result registers
  logic        changed;
  logic [7:0]  byte_res, flag_res, vx_res;
  logic [63:0] row_res;

  // ram ports
  logic            reg_we;
  logic [3:0]      reg_waddr, reg_raddr;
  logic [7:0]      reg_wdata, reg_rdata, reg_rd;
  logic            regv_q;
  logic            mem_we;
  logic [MA_W-1:0] mem_waddr, mem_raddr;
  logic [7:0]      mem_wdata, mem_rdata;
  logic            fb_we;
  logic [ROW_W-1:0] fb_waddr, fb_raddr;
  logic [SW-1:0]   fb_wdata, fb_rdata, fb_rd;
  logic            fbv_q;
  logic            stk_we;
  logic [SP_W-1:0] stk_waddr;
  logic [11:0]     stk_rdata;

  // opcode fields
  logic [3:0]  grp, rx, ry, nn;
  logic [7:0]  kk;
  logic [11:0] nnn;
  assign grp = opc_q[15:12];
  assign rx  = opc_q[11:8];
  assign ry  = opc_q[7:4];
  assign nn  = opc_q[3:0];
  assign kk  = opc_q[7:0];
  assign nnn = opc_q[11:0];

  logic is_cls, is_ret, is_draw, is_bcd, is_str, is_ldr, is_memop, is_flagop;
  assign is_cls    = (opc_q == OPC_CLS);
  assign is_ret    = (opc_q == OPC_RET);
  assign is_draw   = (grp == GRP_DRW);
  assign is_bcd    = (grp == GRP_MISC) && (kk == MISC_BCD);
  assign is_str    = (grp == GRP_MISC) && (kk == MISC_STR);
  assign is_ldr    = (grp == GRP_MISC) && (kk == MISC_LDR);
  assign is_memop  = is_draw || is_bcd || is_str || is_ldr;
  assign is_flagop = (grp == GRP_ALU) && ((nn == ALU_ADD) || (nn == ALU_SUB) ||
                     (nn == ALU_SHR) || (nn == ALU_SUBN) || (nn == ALU_SHL));

  // reads of stores with a reset value
  assign reg_rd = regv_q ? reg_rdata : 8'h00;
  assign fb_rd  = fbv_q ? fb_rdata : '0;

  // pointer wrap
  logic [MA_W-1:0]  mptr_inc;
  logic [ROW_W-1:0] row_inc;
  logic [SP_W-1:0]  sp_inc, sp_dec;
  assign mptr_inc = (mptr == MA_W'(MEM_BYTES - 1)) ? '0 : mptr + 1'b1;
  assign row_inc  = (rowptr == ROW_W'(SCREEN_HEIGHT - 1)) ? '0 : rowptr + 1'b1;
  assign sp_inc   = (sp == SP_W'(STACK_DEPTH - 1)) ? '0 : sp + 1'b1;
  assign sp_dec   = (sp == '0) ? SP_W'(STACK_DEPTH - 1) : sp - 1'b1;

  // shared compare/subtract unit for the modulo steps
  logic [23:0] mod_dsh;
  logic        mod_ge;
  logic [15:0] mod_res;
  assign mod_dsh = 24'(mod_div) << mod_k;
  assign mod_ge  = {8'h00, mod_acc} >= mod_dsh;
  assign mod_res = mod_ge ? (mod_acc - mod_dsh[15:0]) : mod_acc;

  // 8xyN alu
  logic [8:0] alu_sum;
  logic [7:0] alu_res;
  logic       alu_flag;
  assign alu_sum = {1'b0, vx_q} + {1'b0, vy_q};
  always_comb begin
    alu_flag = 1'b0;
    case (nn)
      ALU_MOV:  alu_res = vy_q;
      ALU_OR:   alu_res = vx_q | vy_q;
      ALU_AND:  alu_res = vx_q & vy_q;
      ALU_XOR:  alu_res = vx_q ^ vy_q;
      ALU_ADD: begin
        alu_res  = alu_sum[7:0];
        alu_flag = alu_sum[8];
      end
      ALU_SUB: begin
        alu_res  = vx_q - vy_q;
        alu_flag = vx_q > vy_q;
      end
      ALU_SHR: begin
        alu_res  = {1'b0, vx_q[7:1]};
        alu_flag = vx_q[0];
      end
      ALU_SUBN: begin
        alu_res  = vy_q - vx_q;
        alu_flag = vy_q > vx_q;
      end
      ALU_SHL: begin
        alu_res  = {vx_q[6:0], 1'b0};
        alu_flag = vx_q[7];
      end
      default:  alu_res = vx_q;
    endcase
  end

  // key state for skips
  logic key_hit;
  assign key_hit = (vx_q <= 8'd15) ? keys_q[vx_q[3:0]] : 1'b0;

  // sprite row placed on the screen with horizontal wrap
  logic [7:0]   spr_rev;
  logic [127:0] spr_wide;
  logic [SW-1:0] spr_mask;
  logic          coll;
  always_comb begin
    for (int c = 0; c < 8; c++) begin
      spr_rev[c] = mem_rdata[7 - c];
    end
  end
  assign spr_wide = 128'(spr_rev) << colbase;
  assign spr_mask = spr_wide[SW-1:0] | spr_wide[2*SW-1:SW];
  assign coll     = |(fb_rd & spr_mask);

  // next state and ram controls
  always_comb begin
    state_next = state;
    reg_we     = 1'b0;
    reg_waddr  = rx;
    reg_wdata  = 8'h00;
    reg_raddr  = rx;
    mem_we     = 1'b0;
    mem_waddr  = mptr;
    mem_wdata  = 8'h00;
    mem_raddr  = mptr;
    fb_we      = 1'b0;
    fb_waddr   = rowptr;
    fb_wdata   = fb_rd ^ spr_mask;
    fb_raddr   = rowptr;
    stk_we     = 1'b0;
    stk_waddr  = sp_inc;
    case (state)
      ST_IDLE: begin
        if (start) begin
          case (item_op_t'(op))
            OP_EXEC:  state_next = ST_RX;
            OP_ROW:   state_next = ST_ROW;
            default:  state_next = ST_MOD;
          endcase
        end
      end
      ST_RX: begin
        reg_raddr  = rx;
        state_next = ST_RY;
      end
      ST_RY: begin
        reg_raddr  = ry;
        state_next = ST_R0;
      end
      ST_R0: begin
        reg_raddr  = 4'h0;
        state_next = ST_EXEC;
      end
      ST_EXEC: begin
        state_next = ST_FX;
        if (!is_cls && !is_ret) begin
          case (grp)
            GRP_CALL: stk_we = 1'b1;
            GRP_LD: begin
              reg_we    = 1'b1;
              reg_wdata = kk;
            end
            GRP_ADD: begin
              reg_we    = 1'b1;
              reg_wdata = vx_q + kk;
            end
            GRP_ALU: begin
              if (nn <= ALU_SUBN || nn == ALU_SHL) begin
                reg_we    = 1'b1;
                reg_wdata = alu_res;
              end
              if (is_flagop) begin
                state_next = ST_WF;
              end
            end
            GRP_RND: begin
              reg_we    = 1'b1;
              reg_wdata = rnd_q & kk;
            end
            GRP_MISC: begin
              if (kk == MISC_GDT) begin
                reg_we    = 1'b1;
                reg_wdata = delay_reg;
              end
            end
            default: ;
          endcase
          if (is_memop) begin
            state_next = ST_MOD;
          end
        end
      end
      ST_MOD: begin
        if (mod_k == '0) begin
          case (mod_tgt)
            TGT_I: begin
              if (is_draw)     state_next = ST_MOD;
              else if (is_bcd) state_next = ST_BCD;
              else if (is_str) state_next = ST_STR;
              else             state_next = ST_LDR;
            end
            TGT_X:   state_next = ST_MOD;
            TGT_Y:   state_next = (nn == 4'h0) ? ST_WF : ST_DRD;
            default: state_next = (item_op_t'(op_q) == OP_WRITE) ? ST_HWR : ST_HRD;
          endcase
        end
      end
      ST_DRD: state_next = ST_DWR;
      ST_DWR: begin
        fb_we      = 1'b1;
        state_next = (cnt == nn - 4'd1) ? ST_WF : ST_DRD;
      end
      ST_BCD: begin
        mem_we     = 1'b1;
        mem_wdata  = bcd_digit(vx_q, cnt[1:0]);
        state_next = (cnt == 4'd2) ? ST_FX : ST_BCD;
      end
      ST_STR: begin
        reg_raddr  = cnt;
        state_next = ST_STW;
      end
      ST_STW: begin
        mem_we     = 1'b1;
        mem_wdata  = reg_rd;
        state_next = (cnt == rx) ? ST_FX : ST_STR;
      end
      ST_LDR: state_next = ST_LDW;
      ST_LDW: begin
        reg_we     = 1'b1;
        reg_waddr  = cnt;
        reg_wdata  = mem_rdata;
        state_next = (cnt == rx) ? ST_FX : ST_LDR;
      end
      ST_HWR: begin
        mem_we     = 1'b1;
        mem_wdata  = data_q;
        state_next = ST_FX;
      end
      ST_HRD: state_next = ST_HRC;
      ST_HRC: state_next = ST_FX;
      ST_ROW: begin
        fb_raddr   = addr_q[ROW_W-1:0];
        state_next = ST_ROWC;
      end
      ST_ROWC: state_next = ST_FX;
      ST_WF: begin
        reg_we     = 1'b1;
        reg_waddr  = FLAG_REG;
        reg_wdata  = flag_q;
        state_next = ST_FX;
      end
      ST_FX: begin
        reg_raddr  = FLAG_REG;
        state_next = ST_FY;
      end
      ST_FY: begin
        reg_raddr  = rx;
        state_next = ST_FD;
      end
      ST_FD: state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      pc        <= 12'h200;
      index_reg <= 16'h0000;
      sp        <= '0;
      delay_reg <= 8'h00;
      sound_reg <= 8'h00;
      reg_valid <= '0;
      fb_valid  <= '0;
      done      <= 1'b0;
    end else begin
      done <= (state == ST_FD);
      if (reg_we) begin
        reg_valid[reg_waddr] <= 1'b1;
      end
      if (fb_we) begin
        fb_valid[fb_waddr] <= 1'b1;
      end
      if (state == ST_EXEC) begin
        if (is_cls) begin
          fb_valid <= '0;
        end else if (is_ret) begin
          pc <= stk_rdata;
          sp <= sp_dec;
        end else begin
          case (grp)
            GRP_JP: pc <= nnn;
            GRP_CALL: begin
              sp <= sp_inc;
              pc <= nnn;
            end
            GRP_SE:   if (vx_q == kk) pc <= pc + 12'd2;
            GRP_SNE:  if (vx_q != kk) pc <= pc + 12'd2;
            GRP_SER:  if (vx_q == vy_q) pc <= pc + 12'd2;
            GRP_SNER: if (vx_q != vy_q) pc <= pc + 12'd2;
            GRP_LDI:  index_reg <= {4'h0, nnn};
            GRP_JPV:  pc <= nnn + {4'h0, reg_rd};
            GRP_KEY: begin
              if ((kk == KEY_DOWN && key_hit) || (kk == KEY_UP && !key_hit)) begin
                pc <= pc + 12'd2;
              end
            end
            GRP_MISC: begin
              case (kk)
                MISC_SDT: delay_reg <= vx_q;
                MISC_SST: sound_reg <= vx_q;
                MISC_ADI: index_reg <= index_reg + {8'h00, vx_q};
                MISC_FNT: index_reg <= 16'(vx_q * FONT_BYTES);
                default: ;
              endcase
            end
            default: ;
          endcase
        end
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    regv_q <= reg_valid[reg_raddr];
    fbv_q  <= fb_valid[fb_raddr];
    case (state)
      ST_IDLE: begin
        if (start) begin
          op_q     <= op;
          opc_q    <= opcode;
          keys_q   <= keys_down;
          rnd_q    <= random_byte;
          addr_q   <= mem_addr;
          data_q   <= mem_data;
          changed  <= 1'b0;
          byte_res <= 8'h00;
          row_res  <= 64'h0;
          mod_acc  <= {4'h0, mem_addr};
          mod_div  <= 17'(MEM_BYTES);
          mod_k    <= MOD_STEPS;
          mod_tgt  <= TGT_HOST;
        end
      end
      ST_RY: vx_q <= reg_rd;
      ST_R0: vy_q <= reg_rd;
      ST_EXEC: begin
        flag_q <= {7'b0, alu_flag};
        if (is_cls || is_draw) begin
          changed <= 1'b1;
        end
        mod_acc <= index_reg;
        mod_div <= 17'(MEM_BYTES);
        mod_k   <= MOD_STEPS;
        mod_tgt <= TGT_I;
      end
      ST_MOD: begin
        if (mod_k != '0) begin
          mod_acc <= mod_res;
          mod_k   <= mod_k - 3'd1;
        end else begin
          cnt <= 4'h0;
          hit <= 1'b0;
          case (mod_tgt)
            TGT_I: begin
              mptr    <= MA_W'(mod_res);
              mod_acc <= {8'h00, vx_q};
              mod_div <= 17'(SCREEN_WIDTH);
              mod_k   <= MOD_STEPS;
              mod_tgt <= TGT_X;
            end
            TGT_X: begin
              colbase <= COL_W'(mod_res);
              mod_acc <= {8'h00, vy_q};
              mod_div <= 17'(SCREEN_HEIGHT);
              mod_k   <= MOD_STEPS;
              mod_tgt <= TGT_Y;
            end
            TGT_Y: begin
              rowptr <= ROW_W'(mod_res);
              flag_q <= 8'h00;
            end
            default: mptr <= MA_W'(mod_res);
          endcase
        end
      end
      ST_DWR: begin
        hit    <= hit | coll;
        flag_q <= {7'b0, hit | coll};
        cnt    <= cnt + 4'd1;
        mptr   <= mptr_inc;
        rowptr <= row_inc;
      end
      ST_BCD, ST_STW, ST_LDW: begin
        cnt  <= cnt + 4'd1;
        mptr <= mptr_inc;
      end
      ST_HRC:  byte_res <= mem_rdata;
      ST_ROWC: row_res <= (addr_q < 12'(SCREEN_HEIGHT)) ? 64'(fb_rd) : 64'h0;
      ST_FY:   flag_res <= reg_rd;
      ST_FD:   vx_res <= reg_rd;
      default: ;
    endcase
  end

  // stores
  c8ie_ram #(.WIDTH(8), .DEPTH(16)) u_regs (
    .clk(clk), .we(reg_we), .waddr(reg_waddr), .wdata(reg_wdata),
    .raddr(reg_raddr), .rdata(reg_rdata)
  );

  c8ie_ram #(.WIDTH(8), .DEPTH(MEM_BYTES)) u_mem (
    .clk(clk), .we(mem_we), .waddr(mem_waddr), .wdata(mem_wdata),
    .raddr(mem_raddr), .rdata(mem_rdata)
  );

  c8ie_ram #(.WIDTH(SW), .DEPTH(SCREEN_HEIGHT)) u_frame (
    .clk(clk), .we(fb_we), .waddr(fb_waddr), .wdata(fb_wdata),
    .raddr(fb_raddr), .rdata(fb_rdata)
  );

  c8ie_ram #(.WIDTH(12), .DEPTH(STACK_DEPTH)) u_stack (
    .clk(clk), .we(stk_we), .waddr(stk_waddr), .wdata(pc),
    .raddr(sp), .rdata(stk_rdata)
  );

  // outputs
  assign busy           = (state != ST_IDLE);
  assign prog_counter   = pc;
  assign index_value    = index_reg;
  assign flag_value     = flag_res;
  assign vx_value       = vx_res;
  assign delay_count    = delay_reg;
  assign sound_count    = sound_reg;
  assign screen_changed = changed;
  assign read_byte      = byte_res;
  assign screen_row     = row_res;

endmodule

// File: hdl/c8ie_ram.sv
module c8ie_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // one write port, registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: hdl/c8ie_checker.sv
module c8ie_checker (
  input logic        clk,
  input logic        rst,
  input logic        start,
  input logic        busy,
  input logic        done,
  input logic [11:0] prog_counter
);

  // a result only shows once the block has gone idle
  a_done_idle: assert property (@(posedge clk) disable iff (rst) done |-> !busy)
    else $error("done while busy");

  // a result always follows a busy period
  a_done_after_busy: assert property (@(posedge clk) disable iff (rst) done |-> $past(busy))
    else $error("done without an item");

  // an accepted item makes the block busy
  a_accept_busy: assert property (@(posedge clk) disable iff (rst) (start && !busy) |=> busy)
    else $error("item accepted but not busy");

  // pc moves only while an item is at work
  a_pc_hold: assert property (@(posedge clk) disable iff (rst)
      (!busy && !start) |=> $stable(prog_counter))
    else $error("pc changed while idle");

endmodule

bind chip8_instruction_execute_core c8ie_checker u_c8ie_checker (
  .clk(clk), .rst(rst), .start(start), .busy(busy), .done(done),
  .prog_counter(prog_counter)
);

// File: sim/chip8_instruction_execute_core_tb.sv
`timescale 1ns / 100ps

module chip8_instruction_execute_core_tb;
  import c8ie_pkg::*;

  localparam int MEM_BYTES   = 4096;
  localparam int STACK_DEPTH = 16;
  localparam int SCR_W       = 64;
  localparam int SCR_H       = 32;
  localparam int FONT_BYTES  = 5;
  localparam int STALL_LIMIT = 3000;
  localparam int RANDOM_ITEMS = 400;

  typedef struct {
    item_op_t    op;
    logic [15:0] opcode;
    logic [15:0] keys;
    logic [7:0]  rnd;
    logic [11:0] addr;
    logic [7:0]  data;
    bit          drain;
  } chip_item_t;

  typedef struct {
    logic [11:0] pc;
    logic [15:0] index;
    logic [7:0]  flag;
    logic [7:0]  vx;
    logic [7:0]  delay;
    logic [7:0]  sound;
    logic        changed;
    logic [7:0]  rbyte;
    logic [63:0] row;
  } chip_state_t;

  logic        clk;
  logic        rst;
  logic        start;
  logic        busy;
  logic        done;
  logic [1:0]  op;
  logic [15:0] opcode;
  logic [15:0] keys_down;
  logic [7:0]  random_byte;
  logic [11:0] mem_addr;
  logic [7:0]  mem_data;
  logic [11:0] prog_counter;
  logic [15:0] index_value;
  logic [7:0]  flag_value;
  logic [7:0]  vx_value;
  logic [7:0]  delay_count;
  logic [7:0]  sound_count;
  logic        screen_changed;
  logic [7:0]  read_byte;
  logic [63:0] screen_row;

  chip8_instruction_execute_core i_dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .done(done),
    .op(op), .opcode(opcode), .keys_down(keys_down), .random_byte(random_byte),
    .mem_addr(mem_addr), .mem_data(mem_data),
    .prog_counter(prog_counter), .index_value(index_value), .flag_value(flag_value),
    .vx_value(vx_value), .delay_count(delay_count), .sound_count(sound_count),
    .screen_changed(screen_changed), .read_byte(read_byte), .screen_row(screen_row)
  );

  // shadow machine state
  logic [7:0]  v_regs [16];
  logic [15:0] i_reg;
  logic [11:0] pc_reg;
  logic [3:0]  sp_reg;
  logic [11:0] ret_stack [STACK_DEPTH];
  bit          ret_written [STACK_DEPTH];
  logic [7:0]  delay_reg;
  logic [7:0]  sound_reg;
  logic [7:0]  ram [MEM_BYTES];
  bit          ram_written [MEM_BYTES];
  logic [63:0] frame [SCR_H];

  chip_item_t  pending_items [$];
  chip_state_t pending_states [$];
  chip_state_t awaited_states [$];
  chip_item_t  cur_item;
  chip_state_t cur_state;

  int errors;
  int sent_cnt;
  int accept_cnt;
  int result_cnt;
  int idle_cycles;
  int gap_left;
  bit gen_done;
  int n_exec, n_draw, n_host;

  // clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // execute one item on the shadow state, return what the block should show
  function automatic chip_state_t run_item(chip_item_t s);
    chip_state_t res;
    logic [3:0]  x, y, n;
    logic [7:0]  kk, vx, vy, bits;
    logic [11:0] nnn;
    logic [8:0]  sum;
    logic        hit, pressed;
    int          rw, col;
    x = s.opcode[11:8];
    y = s.opcode[7:4];
    n = s.opcode[3:0];
    kk = s.opcode[7:0];
    nnn = s.opcode[11:0];
    vx = v_regs[x];
    vy = v_regs[y];
    res.changed = 1'b0;
    res.rbyte = '0;
    res.row = '0;
    case (s.op)
      OP_EXEC: begin
        if (s.opcode == OPC_CLS) begin
          for (int r = 0; r < SCR_H; r++) frame[r] = '0;
          res.changed = 1'b1;
        end else if (s.opcode == OPC_RET) begin
          pc_reg = ret_stack[sp_reg];
          sp_reg = sp_reg - 4'd1;
        end else begin
          case (s.opcode[15:12])
            GRP_JP: pc_reg = nnn;
            GRP_CALL: begin
              sp_reg = sp_reg + 4'd1;
              ret_stack[sp_reg] = pc_reg;
              ret_written[sp_reg] = 1'b1;
              pc_reg = nnn;
            end
            GRP_SE:   if (vx == kk) pc_reg = pc_reg + 12'd2;
            GRP_SNE:  if (vx != kk) pc_reg = pc_reg + 12'd2;
            GRP_SER:  if (vx == vy) pc_reg = pc_reg + 12'd2;
            GRP_SNER: if (vx != vy) pc_reg = pc_reg + 12'd2;
            GRP_LD:   v_regs[x] = kk;
            GRP_ADD:  v_regs[x] = vx + kk;
            GRP_ALU: begin
              // flag is written last so it wins when x is VF
              case (n)
                ALU_MOV: v_regs[x] = vy;
                ALU_OR:  v_regs[x] = vx | vy;
                ALU_AND: v_regs[x] = vx & vy;
                ALU_XOR: v_regs[x] = vx ^ vy;
                ALU_ADD: begin
                  sum = {1'b0, vx} + {1'b0, vy};
                  v_regs[x] = sum[7:0];
                  v_regs[FLAG_REG] = {7'b0, sum[8]};
                end
                ALU_SUB: begin
                  v_regs[x] = vx - vy;
                  v_regs[FLAG_REG] = {7'b0, vx > vy};
                end
                ALU_SHR: begin
                  v_regs[x] = vx >> 1;
                  v_regs[FLAG_REG] = {7'b0, vx[0]};
                end
                ALU_SUBN: begin
                  v_regs[x] = vy - vx;
                  v_regs[FLAG_REG] = {7'b0, vy > vx};
                end
                ALU_SHL: begin
                  v_regs[x] = vx << 1;
                  v_regs[FLAG_REG] = {7'b0, vx[7]};
                end
                default: ;
              endcase
            end
            GRP_LDI: i_reg = {4'b0, nnn};
            GRP_JPV: pc_reg = nnn + {4'b0, v_regs[0]};
            GRP_RND: v_regs[x] = s.rnd & kk;
            GRP_DRW: begin
              // xor sprite with wrap on both axes
              hit = 1'b0;
              for (int r = 0; r < n; r++) begin
                bits = ram[(int'(i_reg) + r) % MEM_BYTES];
                rw = (int'(vy) + r) % SCR_H;
                for (int c = 0; c < 8; c++) begin
                  if (bits[7 - c]) begin
                    col = (int'(vx) + c) % SCR_W;
                    if (frame[rw][col]) hit = 1'b1;
                    frame[rw][col] = ~frame[rw][col];
                  end
                end
              end
              v_regs[FLAG_REG] = {7'b0, hit};
              res.changed = 1'b1;
            end
            GRP_KEY: begin
              pressed = (vx <= 8'd15) ? s.keys[vx[3:0]] : 1'b0;
              if (kk == KEY_DOWN && pressed) pc_reg = pc_reg + 12'd2;
              else if (kk == KEY_UP && !pressed) pc_reg = pc_reg + 12'd2;
            end
            GRP_MISC: begin
              case (kk)
                MISC_GDT: v_regs[x] = delay_reg;
                MISC_SDT: delay_reg = vx;
                MISC_SST: sound_reg = vx;
                MISC_ADI: i_reg = i_reg + {8'b0, vx};
                MISC_FNT: i_reg = 16'(int'(vx) * FONT_BYTES);
                MISC_BCD: begin
                  ram[int'(i_reg) % MEM_BYTES] = vx / 8'd100;
                  ram[(int'(i_reg) + 1) % MEM_BYTES] = (vx / 8'd10) % 8'd10;
                  ram[(int'(i_reg) + 2) % MEM_BYTES] = vx % 8'd10;
                  for (int k = 0; k < 3; k++) ram_written[(int'(i_reg) + k) % MEM_BYTES] = 1'b1;
                end
                MISC_STR: begin
                  for (int k = 0; k <= int'(x); k++) begin
                    ram[(int'(i_reg) + k) % MEM_BYTES] = v_regs[k];
                    ram_written[(int'(i_reg) + k) % MEM_BYTES] = 1'b1;
                  end
                end
                MISC_LDR: begin
                  for (int k = 0; k <= int'(x); k++)
                    v_regs[k] = ram[(int'(i_reg) + k) % MEM_BYTES];
                end
                default: ;
              endcase
            end
            default: ;
          endcase
        end
      end
      OP_WRITE: begin
        ram[s.addr] = s.data;
        ram_written[s.addr] = 1'b1;
      end
      OP_READ: res.rbyte = ram[s.addr];
      default: if (s.addr < SCR_H) res.row = frame[s.addr];
    endcase
    res.pc = pc_reg;
    res.index = i_reg;
    res.flag = v_regs[FLAG_REG];
    res.vx = v_regs[x];
    res.delay = delay_reg;
    res.sound = sound_reg;
    return res;
  endfunction

  task automatic push_item(chip_item_t s);
    pending_items.push_back(s);
    pending_states.push_back(run_item(s));
    if (s.op == OP_EXEC) n_exec++;
    else n_host++;
    if (s.op == OP_EXEC && s.opcode[15:12] == GRP_DRW) n_draw++;
  endtask

  // host write of a random byte to a memory cell that was never written
  task automatic fill_cell(int a);
    chip_item_t w;
    if (!ram_written[a]) begin
      w.op = OP_WRITE;
      w.opcode = 16'($urandom);
      w.keys = 16'($urandom);
      w.rnd = 8'($urandom);
      w.addr = 12'(a);
      w.data = 8'($urandom);
      w.drain = 1'b0;
      push_item(w);
    end
  endtask

  // queue an item, first making sure it only reads stores that hold data
  task automatic queue_item(chip_item_t s);
    if (s.op == OP_READ) fill_cell(int'(s.addr));
    if (s.op == OP_EXEC) begin
      if (s.opcode == OPC_RET && !ret_written[sp_reg])
        s.opcode = {GRP_CALL, 12'($urandom)};
      if (s.opcode[15:12] == GRP_DRW)
        for (int r = 0; r < s.opcode[3:0]; r++) fill_cell((int'(i_reg) + r) % MEM_BYTES);
      if (s.opcode[15:12] == GRP_MISC && s.opcode[7:0] == MISC_LDR)
        for (int k = 0; k <= int'(s.opcode[11:8]); k++)
          fill_cell((int'(i_reg) + k) % MEM_BYTES);
    end
    push_item(s);
  endtask

  task automatic exec_op(logic [15:0] opc);
    chip_item_t s;
    s.op = OP_EXEC;
    s.opcode = opc;
    s.keys = 16'($urandom);
    s.rnd = 8'($urandom);
    s.addr = 12'($urandom);
    s.data = 8'($urandom);
    s.drain = 1'b0;
    queue_item(s);
  endtask

  task automatic host_op(item_op_t kind, logic [11:0] a, logic [7:0] d, bit drain);
    chip_item_t s;
    s.op = kind;
    s.opcode = 16'($urandom);
    s.keys = 16'($urandom);
    s.rnd = 8'($urandom);
    s.addr = a;
    s.data = d;
    s.drain = drain;
    queue_item(s);
  endtask

  function automatic logic [15:0] random_opcode();
    logic [3:0] grp;
    logic [15:0] o;
    grp = 4'($urandom);
    o = {grp, 12'($urandom)};
    case (grp)
      4'h0: begin
        case ($urandom_range(0, 3))
          0: o = OPC_CLS;
          1, 2: o = OPC_RET;
          default: ;
        endcase
      end
      GRP_LD: if ($urandom_range(0, 1)) o[7:0] = 8'($urandom_range(0, 20));
      GRP_ALU: begin
        case ($urandom_range(0, 9))
          0: o[3:0] = ALU_MOV;
          1: o[3:0] = ALU_OR;
          2: o[3:0] = ALU_AND;
          3: o[3:0] = ALU_XOR;
          4: o[3:0] = ALU_ADD;
          5: o[3:0] = ALU_SUB;
          6: o[3:0] = ALU_SHR;
          7: o[3:0] = ALU_SUBN;
          8: o[3:0] = ALU_SHL;
          default: ;
        endcase
      end
      GRP_DRW: if ($urandom_range(0, 3) != 0) o[3:0] = 4'($urandom_range(0, 4));
      GRP_KEY: begin
        case ($urandom_range(0, 4))
          0, 1: o[7:0] = KEY_DOWN;
          2, 3: o[7:0] = KEY_UP;
          default: ;
        endcase
      end
      GRP_MISC: begin
        case ($urandom_range(0, 9))
          0: o[7:0] = MISC_GDT;
          1: o[7:0] = MISC_SDT;
          2: o[7:0] = MISC_SST;
          3: o[7:0] = MISC_ADI;
          4: o[7:0] = MISC_FNT;
          5: o[7:0] = MISC_BCD;
          6: o[7:0] = MISC_STR;
          7: o[7:0] = MISC_LDR;
          default: ;
        endcase
      end
      default: ;
    endcase
    return o;
  endfunction

  // reset and stimulus
  initial begin
    rst = 1'b1;
    errors = 0;
    gen_done = 1'b0;
    n_exec = 0;
    n_draw = 0;
    n_host = 0;
    for (int k = 0; k < 16; k++) v_regs[k] = '0;
    for (int k = 0; k < STACK_DEPTH; k++) begin
      ret_stack[k] = '0;
      ret_written[k] = 1'b0;
    end
    for (int k = 0; k < MEM_BYTES; k++) begin
      ram[k] = '0;
      ram_written[k] = 1'b0;
    end
    for (int k = 0; k < SCR_H; k++) frame[k] = '0;
    i_reg = '0;
    pc_reg = 12'h200;
    sp_reg = '0;
    delay_reg = '0;
    sound_reg = '0;

    // directed: edges of memory, draws with wrap and collision, alu flags
    host_op(OP_WRITE, 12'hfff, 8'hff, 1'b0);
    host_op(OP_READ, 12'hfff, 8'h00, 1'b0);
    host_op(OP_WRITE, 12'h000, 8'h80, 1'b0);
    exec_op(16'h60ff);
    exec_op(16'h613f);
    exec_op(16'h621f);
    exec_op(16'hafff);
    exec_op(16'hd122);
    exec_op(16'hd122);
    exec_op(16'hd120);
    host_op(OP_ROW, 12'd31, 8'h00, 1'b1);
    host_op(OP_ROW, 12'd32, 8'h00, 1'b0);
    exec_op(16'h00e0);
    exec_op(16'h8f04);
    exec_op(16'h8015);
    exec_op(16'h8017);
    exec_op(16'h800e);
    exec_op(16'h8f06);
    exec_op(16'h2fff);
    exec_op(16'h00ee);
    exec_op(16'hbfff);
    exec_op(16'hf033);
    exec_op(16'hff55);
    exec_op(16'hff65);
    exec_op(16'he09e);
    exec_op(16'hf01e);

    // random part: mostly opcodes, with host accesses mixed in
    for (int k = 0; k < RANDOM_ITEMS; k++) begin
      case ($urandom_range(0, 9))
        0: host_op(OP_WRITE, 12'($urandom), 8'($urandom), 1'b0);
        1: host_op(OP_READ, 12'($urandom), 8'($urandom), 1'b0);
        2: host_op(OP_ROW, $urandom_range(0, 7) == 0 ? 12'($urandom)
                                                      : 12'($urandom_range(0, SCR_H - 1)),
                   8'($urandom), k % 100 == 50);
        default: exec_op(random_opcode());
      endcase
    end
    gen_done = 1'b1;

    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
  end

  // driver: presents queued items at the falling edge
  always @(negedge clk) begin
    logic next_start;
    next_start = start;
    if (rst) begin
      next_start = 1'b0;
      gap_left = 0;
      sent_cnt = 0;
    end else if (!start || sent_cnt != accept_cnt) begin
      if (start) sent_cnt = accept_cnt;
      next_start = 1'b0;
      if (gap_left > 0) begin
        gap_left--;
      end else if (pending_items.size() > 0 &&
                   (!pending_items[0].drain || awaited_states.size() == 0)) begin
        cur_item = pending_items.pop_front();
        cur_state = pending_states.pop_front();
        op <= cur_item.op;
        opcode <= cur_item.opcode;
        keys_down <= cur_item.keys;
        random_byte <= cur_item.rnd;
        mem_addr <= cur_item.addr;
        mem_data <= cur_item.data;
        next_start = 1'b1;
        // gap before the next item: mostly none or short, now and then long
        case ($urandom_range(0, 19))
          0:             gap_left = $urandom_range(10, 40);
          1, 2, 3, 4, 5: gap_left = $urandom_range(1, 3);
          default:       gap_left = 0;
        endcase
      end
    end
    start <= next_start;
  end

  initial begin
    start = 1'b0;
    op = OP_EXEC;
    opcode = '0;
    keys_down = '0;
    random_byte = '0;
    mem_addr = '0;
    mem_data = '0;
    accept_cnt = 0;
    result_cnt = 0;
    idle_cycles = 0;
  end

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    errors++;
    $display("mismatch on result %0d: %s got %0h expected %0h", result_cnt, what, got, want);
  endtask

  // monitor: accepted items and results at the rising edge
  always @(posedge clk) begin
    chip_state_t e;
    if (!rst) begin
      idle_cycles = idle_cycles + 1;
      if (start && !busy) begin
        awaited_states.push_back(cur_state);
        accept_cnt = accept_cnt + 1;
        idle_cycles = 0;
      end
      if (done) begin
        idle_cycles = 0;
        if (awaited_states.size() == 0) begin
          errors++;
          $display("result %0d arrived with no item outstanding", result_cnt);
        end else begin
          e = awaited_states.pop_front();
          if (prog_counter !== e.pc)
            report_mismatch("prog_counter", 64'(prog_counter), 64'(e.pc));
          if (index_value !== e.index)
            report_mismatch("index_value", 64'(index_value), 64'(e.index));
          if (flag_value !== e.flag)
            report_mismatch("flag_value", 64'(flag_value), 64'(e.flag));
          if (vx_value !== e.vx)
            report_mismatch("vx_value", 64'(vx_value), 64'(e.vx));
          if (delay_count !== e.delay)
            report_mismatch("delay_count", 64'(delay_count), 64'(e.delay));
          if (sound_count !== e.sound)
            report_mismatch("sound_count", 64'(sound_count), 64'(e.sound));
          if (screen_changed !== e.changed)
            report_mismatch("screen_changed", 64'(screen_changed), 64'(e.changed));
          if (read_byte !== e.rbyte)
            report_mismatch("read_byte", 64'(read_byte), 64'(e.rbyte));
          if (screen_row !== e.row) report_mismatch("screen_row", screen_row, e.row);
        end
        result_cnt = result_cnt + 1;
      end
    end
  end

  // end of run and watchdog
  initial begin
    @(negedge rst);
    while (!(gen_done && pending_items.size() == 0 && !start &&
             awaited_states.size() == 0 && idle_cycles < STALL_LIMIT))
      @(posedge clk);
    repeat (100) @(posedge clk);
    $display("%0d results checked: %0d opcodes (%0d draws), %0d host accesses",
             result_cnt, n_exec, n_draw, n_host);
    if (errors == 0 && awaited_states.size() == 0) $display("TB_OK");
    else $display("TB_ERROR");
    $finish;
  end

  always @(posedge clk) begin
    if (idle_cycles >= STALL_LIMIT) begin
      $display("no progress for %0d cycles", STALL_LIMIT);
      $display("TB_ERROR");
      $finish;
    end
  end

endmodule

// File: sim.f
hdl/c8ie_pkg.sv
hdl/c8ie_ram.sv
hdl/chip8_instruction_execute_core.sv
hdl/c8ie_checker.sv
sim/chip8_instruction_execute_core_tb.sv
